// ===== sv/r2hsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
// Used by every module of the block; no dependencies.
`default_nettype none

package r2hsl_pkg;

	// Hue scale: 1/64 degree
	localparam int unsigned HUE_SIXTH = 3840;
	localparam logic [14:0] HUE_FULL  = 15'd23040;

	// Pipelined divider geometry, shared by the saturation and hue paths
	localparam int unsigned DIV_NW = 24;   // numerator bits
	localparam int unsigned DIV_DW = 10;   // divisor bits
	localparam int unsigned DIV_QW = 16;   // quotient bits, one per stage

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Which channel is max, and for red whether hue wraps below zero
	typedef enum logic [1:0] {
		SEC_RED_POS,
		SEC_RED_NEG,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// One classified pixel as it travels from front to back.
	// hue = base(sector) + round(3840 * y / d)
	typedef struct packed {
		sector_t     sector;
		logic        achrom;
		logic [7:0]  d;
		logic [7:0]  den;
		logic [8:0]  y;
		logic [8:0]  lsum;
	} pix_item_t;

	function automatic logic [14:0] sector_base(input sector_t sec);
		logic [14:0] base;
		unique case (sec)
			SEC_RED_POS: base = 15'd0;
			SEC_RED_NEG: base = 15'(HUE_SIXTH * 5);
			SEC_GREEN:   base = 15'(HUE_SIXTH);
			SEC_BLUE:    base = 15'(HUE_SIXTH * 3);
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_to_hsl_converter.sv =====
// Top level of the RGB to HSL converter: front end, queue and back end.
// Depends on r2hsl_pkg, r2hsl_front, r2hsl_queue, r2hsl_back.
//
// Converts one 8-bit RGB pixel per clock into hue (1/64 degree), saturation
// (Q1.15) and lightness as the sum max+min. A pixel is taken on each edge
// where start is high and busy is low; the result is shown for one cycle
// with done high, in transfer order. The receiver cannot stall, so busy
// stays low in steady flow and one pixel per cycle is sustained; saturation
// and hue each run through a 16-stage divider pipeline (one quotient bit
// per stage).
`default_nettype none

module rgb_to_hsl_converter
	import r2hsl_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output logic             busy,
	output logic             done,
	output logic [14:0]      hue_x64,
	output logic [15:0]      saturation_q15,
	output logic [8:0]       lightness_sum,
	output logic             achromatic
);

	pix_item_t  push_item;
	pix_item_t  head_item;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	r2hsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.busy   (busy),
		.full   (full),
		.push   (push),
		.item   (push_item)
	);

	r2hsl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head_item)
	);

	r2hsl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.rdata          (head_item),
		.pop            (pop),
		.done           (done),
		.hue_x64        (hue_x64),
		.saturation_q15 (saturation_q15),
		.lightness_sum  (lightness_sum),
		.achromatic     (achromatic)
	);

endmodule

`default_nettype wire

// ===== sv/r2hsl_front.sv =====
// Front end: takes pixel transfers, finds max/min and the hue sector,
// and pushes one classified item into the queue. Depends on r2hsl_pkg.
`default_nettype none

module r2hsl_front
	import r2hsl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output logic             busy,
	input  wire logic        full,
	output logic             push,
	output pix_item_t        item
);

	logic        vld_s1;
	pix_item_t   item_s1;
	pix_item_t   item_c;
	logic        stall;
	logic        accept;
	logic        red_max;
	logic        green_max;
	logic [7:0]  mx;
	logic [7:0]  mn;
	logic [8:0]  sum;

	assign stall  = vld_s1 && full;
	assign busy   = stall;
	assign accept = start && !busy;
	assign push   = vld_s1 && !full;
	assign item   = item_s1;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			mx = red;
		end else if (green_max) begin
			mx = green;
		end else begin
			mx = blue;
		end
		if ((red <= green) && (red <= blue)) begin
			mn = red;
		end else if (green <= blue) begin
			mn = green;
		end else begin
			mn = blue;
		end
		sum = {1'b0, mx} + {1'b0, mn};

		item_c.d      = mx - mn;
		item_c.lsum   = sum;
		item_c.achrom = (mx == mn);
		// 255 - |sum - 255|
		item_c.den    = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

		// y stays in 0..2d, so 9-bit wraparound in the middle is harmless
		if (red_max) begin
			if (green >= blue) begin
				item_c.sector = SEC_RED_POS;
				item_c.y      = {1'b0, green} - {1'b0, blue};
			end else begin
				item_c.sector = SEC_RED_NEG;
				item_c.y      = {1'b0, item_c.d} + {1'b0, green} - {1'b0, blue};
			end
		end else if (green_max) begin
			item_c.sector = SEC_GREEN;
			item_c.y      = {1'b0, item_c.d} + {1'b0, blue} - {1'b0, red};
		end else begin
			item_c.sector = SEC_BLUE;
			item_c.y      = {1'b0, item_c.d} + {1'b0, red} - {1'b0, green};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

// ===== sv/r2hsl_queue.sv =====
// Short FIFO between the front end and the divider back end.
// Depends on r2hsl_pkg for the item type.
`default_nettype none

module r2hsl_queue
	import r2hsl_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pix_item_t wdata,
	output logic           full,
	input  wire logic      pop,
	output logic           empty,
	output pix_item_t      rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pix_item_t        slot_q [0:DEPTH-1];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");

endmodule

`default_nettype wire

// ===== sv/r2hsl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Requires num < den * 2**DIV_QW. Depends on r2hsl_pkg for its geometry.
`default_nettype none

module r2hsl_div
	import r2hsl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   out_vld,
	output logic [DIV_QW-1:0]      quo
);

	// work_s holds the numerator bits still to shift in, with quotient bits
	// filling from the right; after the last stage it is the quotient.
	logic [DIV_DW-1:0] rem_s  [1:DIV_QW];
	logic [DIV_QW-1:0] work_s [1:DIV_QW];
	logic [DIV_DW-1:0] den_s  [1:DIV_QW];
	logic              vld_s  [1:DIV_QW];

	for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
		logic [DIV_DW-1:0] rem_in;
		logic [DIV_QW-1:0] work_in;
		logic [DIV_DW-1:0] den_in;
		logic              vld_in;
		logic [DIV_DW:0]   trial;
		logic [DIV_DW:0]   diff;
		logic              ge;

		if (i == 0) begin : g_head
			assign rem_in  = DIV_DW'(num[DIV_NW-1:DIV_QW]);
			assign work_in = num[DIV_QW-1:0];
			assign den_in  = den;
			assign vld_in  = in_vld;
		end else begin : g_body
			assign rem_in  = rem_s[i];
			assign work_in = work_s[i];
			assign den_in  = den_s[i];
			assign vld_in  = vld_s[i];
		end

		assign trial = {rem_in, work_in[DIV_QW-1]};
		assign ge    = (trial >= {1'b0, den_in});
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			work_s[i+1] <= {work_in[DIV_QW-2:0], ge};
			den_s[i+1]  <= den_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_in;
			end
		end
	end

	assign out_vld = vld_s[DIV_QW];
	assign quo     = work_s[DIV_QW];

endmodule

`default_nettype wire

// ===== sv/r2hsl_back.sv =====
// Back end: drains the queue, runs saturation and hue through two
// pipelined dividers and registers the result. Depends on r2hsl_pkg, r2hsl_div.
`default_nettype none

module r2hsl_back
	import r2hsl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      empty,
	input  wire pix_item_t rdata,
	output logic           pop,
	output logic           done,
	output logic [14:0]    hue_x64,
	output logic [15:0]    saturation_q15,
	output logic [8:0]     lightness_sum,
	output logic           achromatic
);

	typedef struct packed {
		logic [14:0] base;
		logic [8:0]  lsum;
		logic        achrom;
	} side_t;

	side_t              side_s [1:DIV_QW];
	side_t              side_in;
	logic [DIV_NW-1:0]  sat_num;
	logic [DIV_DW-1:0]  sat_den;
	logic [DIV_NW-1:0]  hue_num;
	logic [DIV_DW-1:0]  hue_den;
	logic               sat_vld;
	logic               hue_vld;
	logic [DIV_QW-1:0]  sat_quo;
	logic [DIV_QW-1:0]  hue_quo;
	logic [15:0]        hue_sum;
	logic [14:0]        hue_wrap;
	logic               done_q;
	logic [14:0]        hue_q;
	logic [15:0]        sat_q;
	logic [8:0]         lsum_q;
	logic               achrom_q;

	// The pipeline never stalls, so the head leaves as soon as it shows up
	assign pop = !empty;

	// round(x / y) = floor((2x + y) / 2y)
	assign sat_num = {rdata.d, 16'b0} + {16'b0, rdata.den};
	assign sat_den = {1'b0, rdata.den, 1'b0};
	// 7680 * y = (y << 13) - (y << 9)
	assign hue_num = {2'b0, rdata.y, 13'b0} - {6'b0, rdata.y, 9'b0} + {16'b0, rdata.d};
	assign hue_den = {1'b0, rdata.d, 1'b0};

	assign side_in.base   = sector_base(rdata.sector);
	assign side_in.lsum   = rdata.lsum;
	assign side_in.achrom = rdata.achrom;

	r2hsl_div u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (pop),
		.num     (sat_num),
		.den     (sat_den),
		.out_vld (sat_vld),
		.quo     (sat_quo)
	);

	r2hsl_div u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (pop),
		.num     (hue_num),
		.den     (hue_den),
		.out_vld (hue_vld),
		.quo     (hue_quo)
	);

	always_ff @(posedge clk) begin
		side_s[1] <= side_in;
		for (int i = 2; i <= DIV_QW; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	assign hue_sum  = {1'b0, side_s[DIV_QW].base} + hue_quo;
	assign hue_wrap = (hue_sum >= {1'b0, HUE_FULL}) ? 15'(hue_sum - {1'b0, HUE_FULL})
	                                                : hue_sum[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sat_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_q    <= side_s[DIV_QW].achrom ? '0 : hue_wrap;
		sat_q    <= side_s[DIV_QW].achrom ? '0 : sat_quo;
		lsum_q   <= side_s[DIV_QW].lsum;
		achrom_q <= side_s[DIV_QW].achrom;
	end

	assign done           = done_q;
	assign hue_x64        = hue_q;
	assign saturation_q15 = sat_q;
	assign lightness_sum  = lsum_q;
	assign achromatic     = achrom_q;

	assert property (@(posedge clk) disable iff (!arst_n) sat_vld == hue_vld)
		else $error("divider pipelines out of step");

	assert property (@(posedge clk) disable iff (!arst_n) done |-> hue_x64 < HUE_FULL)
		else $error("hue not wrapped");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (saturation_q15 <= 16'd32768))
		else $error("saturation above one");

endmodule

`default_nettype wire

// ===== verif/tb_rgb_to_hsl_converter.sv =====
// Testbench for rgb_to_hsl_converter: directed and random pixels, each result
// checked field by field against a built-in HSL predictor kept in a scoreboard.
// Depends only on the converter RTL (r2hsl_pkg and its submodules).
`timescale 1ns / 100ps

module tb_rgb_to_hsl_converter;

	localparam int unsigned DEG60     = 3840;   // 60 degrees in 1/64 degree
	localparam int unsigned DEG360    = 23040;  // full turn in 1/64 degree
	localparam int unsigned SAT_ONE   = 32768;  // 1.0 in Q1.15
	localparam int unsigned N_PIXELS  = 1950;
	localparam int unsigned DRAIN_MAX = 2000;   // cycles allowed for results to arrive
	localparam int unsigned TAIL      = 40;     // quiet cycles after draining, > latency

	typedef struct {
		logic [14:0] hue;
		logic [15:0] sat;
		logic [8:0]  lsum;
		logic        achrom;
	} hsl_t;

	class hsl_scoreboard;
		hsl_t        pending_hsl[$];
		int unsigned errors;
		int unsigned n_sent;
		int unsigned n_checked;
		int unsigned n_gray;
		int unsigned n_max[3];  // red, green, blue max, chromatic only

		function hsl_t predict_hsl(input logic [7:0] r8, input logic [7:0] g8,
				input logic [7:0] b8);
			hsl_t        res;
			int unsigned r, g, b, mx, mn, d, sum, den, hnum, hue;
			r = r8;
			g = g8;
			b = b8;
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			sum = mx + mn;
			res.lsum = sum[8:0];
			res.achrom = (d == 0);
			res.hue = '0;
			res.sat = '0;
			if (d != 0) begin
				// 255 - |sum - 255| folded to min(sum, 510 - sum)
				den = (sum <= 255) ? sum : 510 - sum;
				res.sat = 16'((2 * d * SAT_ONE + den) / (2 * den));
				// unsigned wraparound in the middle terms cancels out
				if (mx == r) begin
					if (g >= b)
						hnum = DEG60 * (g - b);
					else
						hnum = DEG360 * d - DEG60 * (b - g);
				end else if (mx == g) begin
					hnum = 2 * DEG60 * d + DEG60 * b - DEG60 * r;
				end else begin
					hnum = 4 * DEG60 * d + DEG60 * r - DEG60 * g;
				end
				hue = (2 * hnum + d) / (2 * d);
				if (hue >= DEG360) hue -= DEG360;
				res.hue = 15'(hue);
			end
			return res;
		endfunction

		function void note_pixel(input logic [7:0] r, input logic [7:0] g,
				input logic [7:0] b);
			hsl_t exp_hsl;
			exp_hsl = predict_hsl(r, g, b);
			pending_hsl.push_back(exp_hsl);
			n_sent++;
			if (exp_hsl.achrom)
				n_gray++;
			else if (r >= g && r >= b)
				n_max[0]++;
			else if (g >= b)
				n_max[1]++;
			else
				n_max[2]++;
		endfunction

		function void check_result(input hsl_t got);
			hsl_t exp_hsl;
			if (pending_hsl.size() == 0) begin
				$display("%0t: unexpected result hue %0d sat %0d lsum %0d achrom %0d",
					$time, got.hue, got.sat, got.lsum, got.achrom);
				errors++;
				return;
			end
			exp_hsl = pending_hsl.pop_front();
			n_checked++;
			if (got.hue !== exp_hsl.hue) begin
				$display("%0t: hue_x64 expected %0d actual %0d", $time, exp_hsl.hue, got.hue);
				errors++;
			end
			if (got.sat !== exp_hsl.sat) begin
				$display("%0t: saturation_q15 expected %0d actual %0d",
					$time, exp_hsl.sat, got.sat);
				errors++;
			end
			if (got.lsum !== exp_hsl.lsum) begin
				$display("%0t: lightness_sum expected %0d actual %0d",
					$time, exp_hsl.lsum, got.lsum);
				errors++;
			end
			if (got.achrom !== exp_hsl.achrom) begin
				$display("%0t: achromatic expected %0d actual %0d",
					$time, exp_hsl.achrom, got.achrom);
				errors++;
			end
		endfunction
	endclass

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [7:0]  red    = '0;
	logic [7:0]  green  = '0;
	logic [7:0]  blue   = '0;
	logic        busy;
	logic        done;
	logic [14:0] hue_x64;
	logic [15:0] saturation_q15;
	logic [8:0]  lightness_sum;
	logic        achromatic;

	hsl_scoreboard sb = new();

	rgb_to_hsl_converter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.busy           (busy),
		.done           (done),
		.hue_x64        (hue_x64),
		.saturation_q15 (saturation_q15),
		.lightness_sum  (lightness_sum),
		.achromatic     (achromatic)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// results cannot be held off: take every done cycle as it comes
	always @(posedge clk) begin
		hsl_t got;
		if (arst_n && done) begin
			got.hue = hue_x64;
			got.sat = saturation_q15;
			got.lsum = lightness_sum;
			got.achrom = achromatic;
			sb.check_result(got);
		end
	end

	// Present one pixel, hold it until the transfer, then maybe idle a while.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input bit may_idle);
		int unsigned gap;
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_pixel(r, g, b);
		gap = 0;
		if (may_idle)
			while ($urandom_range(99) < 24) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic drain_results();
		int unsigned waited;
		start <= 1'b0;
		waited = 0;
		while (sb.pending_hsl.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_hsl.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending_hsl.size());
			sb.errors += sb.pending_hsl.size();
			sb.pending_hsl.delete();
		end
	endtask

	function automatic logic [7:0] near(input int unsigned base);
		int v;
		v = int'(base) + int'($urandom_range(6)) - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_extreme();
		case ($urandom_range(2))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic rand_pixel(output logic [7:0] r, output logic [7:0] g,
			output logic [7:0] b);
		int unsigned kind, base;
		logic [7:0]  a, c;
		kind = $urandom_range(99);
		base = $urandom_range(255);
		if (kind < 55) begin
			r = 8'($urandom_range(255));
			g = 8'($urandom_range(255));
			b = 8'($urandom_range(255));
		end else if (kind < 70) begin
			// low contrast: small d, including gray
			r = near(base);
			g = near(base);
			b = near(base);
		end else if (kind < 85) begin
			// two channels equal, exercises max/min tie order
			a = 8'(base);
			c = 8'($urandom_range(255));
			case ($urandom_range(2))
				0: begin r = a; g = a; b = c; end
				1: begin r = a; g = c; b = a; end
				default: begin r = c; g = a; b = a; end
			endcase
		end else begin
			r = pick_extreme();
			g = pick_extreme();
			b = pick_extreme();
		end
	endtask

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0] r, g, b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, gray levels, primaries, max ties, wrap region
		send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
		send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
		send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
		send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
		send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
		send_pixel(8'd255, 8'd254, 8'd255, 1'b0);
		send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
		send_pixel(8'd0,   8'd0,   8'd1,   1'b1);
		send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
		send_pixel(8'd128, 8'd127, 8'd127, 1'b0);
		send_pixel(8'd127, 8'd128, 8'd127, 1'b0);
		send_pixel(8'd127, 8'd127, 8'd128, 1'b1);
		send_pixel(8'd170, 8'd85,  8'd0,   1'b0);
		send_pixel(8'd0,   8'd170, 8'd85,  1'b0);
		send_pixel(8'd85,  8'd0,   8'd170, 1'b0);
		send_pixel(8'd200, 8'd10,  8'd199, 1'b1);
		send_pixel(8'd170, 8'd85,  8'd255, 1'b0);
		drain_results();
		@(posedge clk);

		for (int unsigned i = 0; i < N_PIXELS; i++) begin
			rand_pixel(r, g, b);
			// one long stretch at full rate
			send_pixel(r, g, b, !(i >= 700 && i < 1000));
			if (i == 400 || i == 1400) begin
				drain_results();
				@(posedge clk);
			end
		end

		drain_results();
		repeat (TAIL) @(posedge clk);

		$display("Sent %0d pixels (%0d gray, max channel red/green/blue %0d/%0d/%0d)",
			sb.n_sent, sb.n_gray, sb.n_max[0], sb.n_max[1], sb.n_max[2]);
		$display("Checked %0d results, %0d field errors", sb.n_checked, sb.errors);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/r2hsl_pkg.sv
sv/r2hsl_front.sv
sv/r2hsl_queue.sv
sv/r2hsl_div.sv
sv/r2hsl_back.sv
sv/rgb_to_hsl_converter.sv
verif/tb_rgb_to_hsl_converter.sv
